FILE: rtl/core/utg_pkg.sv
// ----------------------------------------------------------------------------
// utg_pkg
// Shared types and constants of the UTF-8 text grid loader: default grid
// dimensions, decoder byte codes and the job record passed from the decoding
// front end to the result back end.
// ----------------------------------------------------------------------------
package utg_pkg;

    localparam int LINE_WIDTH_DEF = 240;
    localparam int ROW_LIMIT_DEF  = 128;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] BOM_BYTE0 = 8'hEF;
    localparam logic [7:0] BOM_BYTE1 = 8'hBB;
    localparam logic [7:0] BOM_BYTE2 = 8'hBF;
    localparam logic [1:0] BOM_DONE  = 2'd3;

    localparam logic [15:0] CODE_CR = 16'h000D;
    localparam logic [15:0] CODE_LF = 16'h000A;

    localparam logic [2:0] LEAD2_PREFIX = 3'b110;
    localparam logic [3:0] LEAD3_PREFIX = 4'b1110;

    localparam logic [1:0] AWAIT_NONE = 2'd0;
    localparam logic [1:0] AWAIT_ONE  = 2'd1;
    localparam logic [1:0] AWAIT_TWO  = 2'd2;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        has_char;
        logic        is_last;
        logic [6:0]  row;
        logic [7:0]  column;
        logic [15:0] code;
        logic [7:0]  lines;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: rtl/core/utg_front.sv
// ----------------------------------------------------------------------------
// utg_front
// Decoding front end. Takes one file byte per cycle unless stalled, assembles
// UTF-8 sequences, strips a leading byte order mark, tracks the grid position
// and queues one job for every byte that places a character or ends the file.
// ----------------------------------------------------------------------------
module utg_front #(
    parameter int LineWidth = utg_pkg::LINE_WIDTH_DEF,
    parameter int RowLimit  = utg_pkg::ROW_LIMIT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               data_valid,
    output logic               data_stall,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,
    input  utg_pkg::q_status_t q_status,
    output logic               push,
    output utg_pkg::job_t      push_job
);
    import utg_pkg::*;

    logic [1:0]  awaited_reg, awaited_next;
    logic [15:0] partial_reg, partial_next;
    logic [1:0]  bom_phase_reg, bom_phase_next;
    logic        bom_match_reg, bom_match_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic        full_reg, full_next;

    logic        accept;
    logic        start;
    logic        ch_valid;
    logic [15:0] ch;
    logic [15:0] code_shift;
    logic [7:0]  bom_expect;
    logic [8:0]  col_inc;
    logic [8:0]  row_inc;
    logic [8:0]  lines_raw;
    job_t        job;

    assign data_stall = q_status.full;
    assign accept     = data_valid && !q_status.full;

    always_comb
    begin
        case (bom_phase_reg)
            2'd0:    bom_expect = BOM_BYTE0;
            2'd1:    bom_expect = BOM_BYTE1;
            2'd2:    bom_expect = BOM_BYTE2;
            default: bom_expect = BOM_BYTE0;
        endcase
    end

    always_comb
    begin
        awaited_next   = awaited_reg;
        partial_next   = partial_reg;
        bom_phase_next = bom_phase_reg;
        bom_match_next = bom_match_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        full_next      = full_reg;
        start          = 1'b0;
        ch_valid       = 1'b0;
        ch             = '0;
        code_shift     = {partial_reg[9:0], data_byte[5:0]};
        col_inc        = {1'b0, col_reg} + 9'd1;
        row_inc        = {1'b0, row_reg} + 9'd1;
        lines_raw      = '0;
        job            = '0;

        if (!full_reg)
        begin
            if (bom_phase_reg != BOM_DONE)
            begin
                if (data_byte != bom_expect)
                begin
                    bom_match_next = 1'b0;
                end
                bom_phase_next = bom_phase_reg + 2'd1;
            end

            if (awaited_reg != AWAIT_NONE)
            begin
                if (final_byte && awaited_reg == AWAIT_TWO)
                begin
                    awaited_next = AWAIT_NONE;
                    partial_next = '0;
                    start        = 1'b1;
                end
                else
                begin
                    partial_next = code_shift;
                    awaited_next = awaited_reg - 2'd1;
                    if (awaited_reg == AWAIT_ONE)
                    begin
                        if (!(bom_phase_reg == 2'd2 && bom_match_next))
                        begin
                            ch_valid = 1'b1;
                            ch       = code_shift;
                        end
                        partial_next = '0;
                    end
                end
            end
            else
            begin
                start = 1'b1;
            end

            if (start)
            begin
                if (!data_byte[7])
                begin
                    ch_valid = 1'b1;
                    ch       = {8'h00, data_byte};
                end
                else if (data_byte[7:5] == LEAD2_PREFIX)
                begin
                    if (!final_byte)
                    begin
                        awaited_next = AWAIT_ONE;
                        partial_next = {11'd0, data_byte[4:0]};
                    end
                end
                else if (data_byte[7:4] == LEAD3_PREFIX)
                begin
                    if (!final_byte)
                    begin
                        awaited_next = AWAIT_TWO;
                        partial_next = {12'd0, data_byte[3:0]};
                    end
                end
            end

            if (ch_valid && ch != CODE_CR)
            begin
                if (ch == CODE_LF)
                begin
                    row_next = row_inc[7:0];
                    col_next = '0;
                    if (row_inc >= 9'(RowLimit))
                    begin
                        full_next = 1'b1;
                    end
                end
                else
                begin
                    job.has_char = 1'b1;
                    job.row      = row_reg[6:0];
                    job.column   = col_reg;
                    job.code     = ch;
                    if (col_inc >= 9'(LineWidth))
                    begin
                        row_next = row_inc[7:0];
                        col_next = '0;
                        if (row_inc >= 9'(RowLimit))
                        begin
                            full_next = 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_inc[7:0];
                    end
                end
            end
        end

        if (final_byte)
        begin
            lines_raw = {1'b0, row_next} + 9'd1;
            if (full_next || lines_raw > 9'(RowLimit))
            begin
                job.lines = 8'(RowLimit);
            end
            else
            begin
                job.lines = lines_raw[7:0];
            end
            job.is_last    = 1'b1;
            awaited_next   = AWAIT_NONE;
            partial_next   = '0;
            bom_phase_next = '0;
            bom_match_next = 1'b1;
            row_next       = '0;
            col_next       = '0;
            full_next      = 1'b0;
        end
    end

    assign push     = accept && (job.has_char || job.is_last);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_reg   <= AWAIT_NONE;
            partial_reg   <= '0;
            bom_phase_reg <= '0;
            bom_match_reg <= 1'b1;
            row_reg       <= '0;
            col_reg       <= '0;
            full_reg      <= 1'b0;
        end
        else if (accept)
        begin
            awaited_reg   <= awaited_next;
            partial_reg   <= partial_next;
            bom_phase_reg <= bom_phase_next;
            bom_match_reg <= bom_match_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            full_reg      <= full_next;
        end
    end

endmodule

FILE: rtl/core/utg_queue.sv
// ----------------------------------------------------------------------------
// utg_queue
// Short job queue between the decoding front end and the result back end,
// so that either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module utg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  utg_pkg::job_t      push_job,
    input  logic               pop,
    output utg_pkg::job_t      pop_job,
    output utg_pkg::q_status_t status
);
    import utg_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/utg_back.sv
// ----------------------------------------------------------------------------
// utg_back
// Result back end. Takes jobs from the queue and turns each into one or two
// result items (a placed character, the end-of-file summary, or both), held
// in an output register.
// ----------------------------------------------------------------------------
module utg_back (
    input  logic               clk,
    input  logic               rst_n,
    input  utg_pkg::q_status_t q_status,
    input  utg_pkg::job_t      pop_job,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               kind,
    output logic [6:0]         row,
    output logic [7:0]         column,
    output logic [15:0]        code_unit,
    output logic [7:0]         line_count,
    output logic               run_end
);
    import utg_pkg::*;

    logic        valid_reg, valid_next;
    logic        kind_reg, kind_next;
    logic [6:0]  row_reg, row_next;
    logic [7:0]  column_reg, column_next;
    logic [15:0] code_reg, code_next;
    logic [7:0]  lines_reg, lines_next;
    logic        run_end_reg, run_end_next;
    logic        pend_reg, pend_next;
    logic [7:0]  pend_lines_reg, pend_lines_next;
    logic        load;

    assign load = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next      = valid_reg;
        kind_next       = kind_reg;
        row_next        = row_reg;
        column_next     = column_reg;
        code_next       = code_reg;
        lines_next      = lines_reg;
        run_end_next    = run_end_reg;
        pend_next       = pend_reg;
        pend_lines_next = pend_lines_reg;
        pop             = 1'b0;

        if (load)
        begin
            if (pend_reg)
            begin
                valid_next   = 1'b1;
                kind_next    = KIND_SUMMARY;
                row_next     = '0;
                column_next  = '0;
                code_next    = '0;
                lines_next   = pend_lines_reg;
                run_end_next = 1'b1;
                pend_next    = 1'b0;
            end
            else if (!q_status.empty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                if (pop_job.has_char)
                begin
                    kind_next       = KIND_CHAR;
                    row_next        = pop_job.row;
                    column_next     = pop_job.column;
                    code_next       = pop_job.code;
                    lines_next      = '0;
                    run_end_next    = !pop_job.is_last;
                    pend_next       = pop_job.is_last;
                    pend_lines_next = pop_job.lines;
                end
                else
                begin
                    kind_next    = KIND_SUMMARY;
                    row_next     = '0;
                    column_next  = '0;
                    code_next    = '0;
                    lines_next   = pop_job.lines;
                    run_end_next = 1'b1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        row_reg        <= row_next;
        column_reg     <= column_next;
        code_reg       <= code_next;
        lines_reg      <= lines_next;
        run_end_reg    <= run_end_next;
        pend_lines_reg <= pend_lines_next;
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign row          = row_reg;
    assign column       = column_reg;
    assign code_unit    = code_reg;
    assign line_count   = lines_reg;
    assign run_end      = run_end_reg;

endmodule

FILE: rtl/core/utg_to_text_grid_loader_dummy.sv
// ----------------------------------------------------------------------------
// utg_check
// Port-level handshake checker for the result channel of the text grid
// loader: a stalled result item stays valid and holds its code unit.
// ----------------------------------------------------------------------------
module utg_check (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [15:0] code_unit
);
    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(code_unit);
    endproperty

    a_hold: assert property (p_hold)
        else $error("Stalled result item changed.");

endmodule

FILE: rtl/core/utf8_to_text_grid_loader.sv
// ----------------------------------------------------------------------------
// utf8_to_text_grid_loader
// Loads a UTF-8 file, one byte per item, onto a text grid and reports each
// placed character with its row and column, then a line count summary.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while data_stall is low. A byte yields
// no result, one character item or one summary item; the final byte of a file
// that also completes a character yields a character item, then the summary,
// while the front end keeps taking bytes into a four-entry job queue. A job
// goes through the queue and then the output register. Lead bytes C0-DF and
// E0-EF start two- and three-byte sequences; other non-ASCII leads are
// dropped, as are a leading byte order mark and CR. LF starts a new row, rows
// wrap at LineWidth, and bytes after RowLimit rows are ignored until the end.
// ----------------------------------------------------------------------------
module utf8_to_text_grid_loader #(
    parameter int LineWidth = utg_pkg::LINE_WIDTH_DEF,
    parameter int RowLimit  = utg_pkg::ROW_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        kind,
    output logic [6:0]  row,
    output logic [7:0]  column,
    output logic [15:0] code_unit,
    output logic [7:0]  line_count,
    output logic        run_end
);
    import utg_pkg::*;

    q_status_t q_status;
    logic      push;
    job_t      push_job;
    logic      pop;
    job_t      pop_job;

    utg_front #(
        .LineWidth (LineWidth),
        .RowLimit  (RowLimit)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    utg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    utg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_job      (pop_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .row          (row),
        .column       (column),
        .code_unit    (code_unit),
        .line_count   (line_count),
        .run_end      (run_end)
    );

    utg_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .code_unit    (code_unit)
    );

    a_summary_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_SUMMARY |-> run_end)
        else $error("Summary item without run end.");

    a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_CHAR |-> 9'(column) < 9'(LineWidth))
        else $error("Character placed beyond the line width.");

    a_line_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_SUMMARY
        |-> line_count != 8'd0 && 9'(line_count) <= 9'(RowLimit))
        else $error("Line count outside the grid.");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push && data_stall)
        else $error("Job pushed into a full queue.");

endmodule
